FILE: hw/rtl/acfb_pkg.sv
// ============================================================================
// AES-128 CFB package
// Shared types, constants and GF(2^8) helpers for the CFB cipher.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package acfb_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int NUM_ROUNDS  = 10;
    localparam int CFG_W       = 64;
    localparam int IDX_W       = 3;
    localparam int CNT_W       = 5;
    localparam int ROUND_W     = 4;

    typedef logic [127:0]       block_t;
    typedef logic [ROUND_W-1:0] round_t;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_KEY_LOW  = 3'd0,
        REG_KEY_HIGH = 3'd1,
        REG_IV_LOW   = 3'd2,
        REG_IV_HIGH  = 3'd3
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINISH
    } seq_state_t;

    // Control from the sequencer to the round datapath.
    typedef struct packed {
        round_t round;
        logic   last;
    } round_ctrl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Round constant for the key schedule step that produces round key r.
    function automatic logic [7:0] rcon(input round_t r);
        logic [7:0] v;
        case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/acfb_key_step.sv
// ============================================================================
// AES-128 key schedule step
// Derives the next round key from the current one, one round per use.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module acfb_key_step (
    input  wire acfb_pkg::block_t key_cur,
    input  wire acfb_pkg::round_t round,
    output acfb_pkg::block_t      key_nxt
);
    import acfb_pkg::*;

    logic [31:0] g_word;
    logic [31:0] w0, w1, w2, w3;

    // Rotate, substitute and add the round constant on the last word.
    always_comb
    begin
        g_word[7:0]   = SBOX[key_cur[111:104]] ^ rcon(round);
        g_word[15:8]  = SBOX[key_cur[119:112]];
        g_word[23:16] = SBOX[key_cur[127:120]];
        g_word[31:24] = SBOX[key_cur[103:96]];
        w0 = key_cur[31:0]   ^ g_word;
        w1 = key_cur[63:32]  ^ w0;
        w2 = key_cur[95:64]  ^ w1;
        w3 = key_cur[127:96] ^ w2;
    end

    assign key_nxt = {w3, w2, w1, w0};

endmodule

`default_nettype wire

FILE: hw/rtl/acfb_round_unit.sv
// ============================================================================
// AES-128 round unit
// One full cipher round: SubBytes, ShiftRows, MixColumns and AddRoundKey.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module acfb_round_unit (
    input  wire acfb_pkg::block_t      state_in,
    input  wire acfb_pkg::block_t      rnd_key,
    input  wire acfb_pkg::round_ctrl_t ctrl,
    output acfb_pkg::block_t           state_out
);
    import acfb_pkg::*;

    logic [7:0] sb  [BLOCK_BYTES];
    logic [7:0] sr  [BLOCK_BYTES];
    logic [7:0] mc  [BLOCK_BYTES];
    logic [7:0] a0, a1, a2, a3;

    // Byte substitution and row shift.
    always_comb
    begin
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            sb[i] = SBOX[state_in[8*i +: 8]];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sr[r + 4*c] = sb[r + 4*((c + r) % 4)];
            end
        end
    end

    // Column mixing, skipped in the last round.
    always_comb
    begin
        a0 = '0;
        a1 = '0;
        a2 = '0;
        a3 = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0 = sr[4*c];
            a1 = sr[4*c+1];
            a2 = sr[4*c+2];
            a3 = sr[4*c+3];
            if (ctrl.last)
            begin
                mc[4*c]   = a0;
                mc[4*c+1] = a1;
                mc[4*c+2] = a2;
                mc[4*c+3] = a3;
            end
            else
            begin
                mc[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                mc[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                mc[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                mc[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
        end
    end

    // Round key addition.
    always_comb
    begin
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            state_out[8*i +: 8] = mc[i] ^ rnd_key[8*i +: 8];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/aes128_cfb_cipher.sv
// ============================================================================
// AES-128 CFB128 cipher
// Encrypts or decrypts one 16-byte block per transfer in CFB128 mode.
// ============================================================================
//
// Usage:
//   Configuration: write the key and IV through cfg_we / cfg_index / cfg_data
//   while the block is idle. Key changes take effect on the next block.
//   Input channel (in_valid / in_ready): one 16-byte block per transfer with
//   its byte count, start flag and direction. A set start_req reloads the
//   feedback register from the IV before the block is processed.
//   Output channel (out_valid / out_ready): one block per input block.
// Block sequence:
//   A block is loaded and whitened, runs ten cipher rounds on a single
//   shared round unit with round keys derived on the fly, and then writes
//   the output register and, for a full block, the feedback. The next block
//   is accepted only after that, so blocks do not overlap.
// Reset clears key, IV and feedback to zero and leaves both channels empty.
// If the receiver stalls, the finished block waits in the output register;
// the following block may still run, and then holds in its last step until
// the output register frees up.
//
`timescale 1ns / 1ps
`default_nettype none

module aes128_cfb_cipher (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_we,
    input  wire [acfb_pkg::IDX_W-1:0]       cfg_index,
    input  wire [acfb_pkg::CFG_W-1:0]       cfg_data,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire [63:0]                      data_low,
    input  wire [63:0]                      data_high,
    input  wire [acfb_pkg::CNT_W-1:0]       byte_count,
    input  wire                             start_req,
    input  wire                             opcode,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic [63:0]                     result_low,
    output logic [63:0]                     result_high,
    output logic [acfb_pkg::CNT_W-1:0]      valid_bytes
);
    import acfb_pkg::*;

    seq_state_t        state_reg, state_next;
    round_t            round_reg, round_next;
    block_t            key_reg, iv_reg, fb_reg;
    block_t            work_reg, work_next;
    block_t            rk_reg, rk_next;
    block_t            din_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              dec_reg;
    logic              out_valid_reg, out_valid_next;
    block_t            res_reg;
    logic [CNT_W-1:0]  res_cnt_reg;

    block_t            round_out;
    round_ctrl_t       rctrl;
    block_t            dout;
    logic [CNT_W-1:0]  cnt_sat;
    logic              in_xfer;
    logic              finish_go;

    assign in_xfer   = in_valid && in_ready;
    assign finish_go = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    assign cnt_sat   = (byte_count > CNT_W'(BLOCK_BYTES)) ? CNT_W'(BLOCK_BYTES) : byte_count;

    // Shared datapath: next round key and one cipher round.
    assign rctrl.round = round_reg;
    assign rctrl.last  = (round_reg == ROUND_W'(NUM_ROUNDS));

    acfb_key_step u_key_step (
        .key_cur (rk_reg),
        .round   (round_reg),
        .key_nxt (rk_next)
    );

    acfb_round_unit u_round (
        .state_in  (work_reg),
        .rnd_key   (rk_next),
        .ctrl      (rctrl),
        .state_out (round_out)
    );

    // Masked output block: keystream XOR input on valid bytes only.
    always_comb
    begin
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            dout[8*i +: 8] = (CNT_W'(i) < cnt_reg) ? (din_reg[8*i +: 8] ^ work_reg[8*i +: 8])
                                                   : 8'h00;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (rctrl.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs and datapath updates.
    always_comb
    begin
        in_ready       = 1'b0;
        round_next     = round_reg;
        work_next      = work_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                round_next = ROUND_W'(1);
                work_next  = (start_req ? iv_reg : fb_reg) ^ key_reg;
            end
            ST_ROUND:
            begin
                work_next  = round_out;
                round_next = round_reg + ROUND_W'(1);
            end
            ST_FINISH:
            begin
                if (finish_go)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default: in_ready = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            key_reg       <= '0;
            iv_reg        <= '0;
            fb_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KEY_LOW:  key_reg[63:0]   <= cfg_data;
                    REG_KEY_HIGH: key_reg[127:64] <= cfg_data;
                    REG_IV_LOW:   iv_reg[63:0]    <= cfg_data;
                    REG_IV_HIGH:  iv_reg[127:64]  <= cfg_data;
                    default:      ;
                endcase
            end
            if (in_xfer && start_req)
            begin
                fb_reg <= iv_reg;
            end
            else if (finish_go && (cnt_reg == CNT_W'(BLOCK_BYTES)))
            begin
                fb_reg <= dec_reg ? din_reg : dout;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        round_reg <= round_next;
        work_reg  <= work_next;
        if (in_xfer)
        begin
            rk_reg  <= key_reg;
            din_reg <= {data_high, data_low};
            cnt_reg <= cnt_sat;
            dec_reg <= opcode;
        end
        else if (state_reg == ST_ROUND)
        begin
            rk_reg <= rk_next;
        end
        if (finish_go)
        begin
            res_reg     <= dout;
            res_cnt_reg <= cnt_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_low  = res_reg[63:0];
    assign result_high = res_reg[127:64];
    assign valid_bytes = res_cnt_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/acfb_checker.sv
// ============================================================================
// AES-128 CFB port checker
// Watches the cipher's channels for sequencing and handshake slips.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module acfb_checker (
    input wire                        clk,
    input wire                        rst_n,
    input wire                        in_valid,
    input wire                        in_ready,
    input wire                        out_valid,
    input wire                        out_ready,
    input wire [acfb_pkg::CNT_W-1:0]  valid_bytes
);
    import acfb_pkg::*;

    // A block in work blocks the input channel on the next cycle.
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a block is in work");

    // A result never shows up in the cycle after an input transfer.
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result appeared too early");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(valid_bytes)))
        else $error("stalled result dropped or changed");

    // The byte count of a result never exceeds one block.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (valid_bytes <= CNT_W'(BLOCK_BYTES)))
        else $error("valid_bytes out of range");

endmodule

bind aes128_cfb_cipher acfb_checker u_acfb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .valid_bytes (valid_bytes)
);

`default_nettype wire
